### sv/qos_traffic_classifier_core_macros.svh
// ----------------------------------------------------------------------------
// qos traffic classifier assertion macros
// shared concurrent assertion forms for the classifier rtl
// ----------------------------------------------------------------------------
`ifndef QOS_TRAFFIC_CLASSIFIER_CORE_MACROS_SVH
`define QOS_TRAFFIC_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication
`define QTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/qtc_pkg.sv
// ----------------------------------------------------------------------------
// qtc package
// sizes, command codes, table access types and helpers of the classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qtc_pkg;

    localparam int DSCP_ENTRIES   = 64;
    localparam int PORT_ENTRIES   = 64;
    localparam int VLAN_ENTRIES   = 64;
    localparam int SUBNET_ENTRIES = 32;

    localparam int PORT_AW = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
    localparam int VLAN_AW = (VLAN_ENTRIES > 1) ? $clog2(VLAN_ENTRIES) : 1;
    localparam int SUB_AW  = (SUBNET_ENTRIES > 1) ? $clog2(SUBNET_ENTRIES) : 1;

    localparam int PV_DEPTH_TOP = (PORT_ENTRIES > VLAN_ENTRIES) ? PORT_ENTRIES
                                                                : VLAN_ENTRIES;
    localparam int TBL_DEPTH_TOP = (PV_DEPTH_TOP > SUBNET_ENTRIES) ? PV_DEPTH_TOP
                                                                   : SUBNET_ENTRIES;
    localparam int IDX_W = $clog2(TBL_DEPTH_TOP + 1);

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [7:0]  CLASS_MAX = 8'd7;
    localparam logic [5:0]  LEN_MAX   = 6'd32;

    localparam logic [2:0] CMD_CLASSIFY = 3'd0;
    localparam logic [2:0] CMD_WR_DSCP  = 3'd1;
    localparam logic [2:0] CMD_WR_PORT  = 3'd2;
    localparam logic [2:0] CMD_WR_VLAN  = 3'd3;
    localparam logic [2:0] CMD_WR_SUB   = 3'd4;
    localparam logic [2:0] CMD_READ     = 3'd5;

    localparam logic [2:0] SRC_DEFAULT = 3'd0;
    localparam logic [2:0] SRC_DSCP    = 3'd1;
    localparam logic [2:0] SRC_PORT    = 3'd2;
    localparam logic [2:0] SRC_VLAN    = 3'd3;
    localparam logic [2:0] SRC_SUBSRC  = 3'd4;
    localparam logic [2:0] SRC_SUBDST  = 3'd5;

    localparam logic CFG_ENABLED = 1'b0;
    localparam logic CFG_DEFAULT = 1'b1;

    typedef struct packed {
        logic        we_dscp;
        logic        we_port;
        logic        we_vlan;
        logic        we_sub;
        logic [5:0]  slot;
        logic        valid;
        logic [7:0]  cls;
        logic [7:0]  proto;
        logic [15:0] port;
        logic [11:0] vid;
        logic [31:0] prefix;
        logic [5:0]  len;
    } t_tbl_wr;

    typedef struct packed {
        logic [5:0]         dscp_addr;
        logic [PORT_AW-1:0] port_addr;
        logic [VLAN_AW-1:0] vlan_addr;
        logic [SUB_AW-1:0]  sub_addr;
    } t_tbl_rd;

    typedef struct packed {
        logic        dscp_v;
        logic [7:0]  dscp_cls;
        logic        port_v;
        logic [7:0]  port_proto;
        logic [15:0] port_port;
        logic [7:0]  port_cls;
        logic        vlan_v;
        logic [11:0] vlan_vid;
        logic [7:0]  vlan_cls;
        logic        sub_v;
        logic [31:0] sub_prefix;
        logic [5:0]  sub_len;
        logic [7:0]  sub_cls;
    } t_tbl_q;

    function automatic logic [31:0] f_prefix_mask(input logic [5:0] len);
        if (len == 6'd0) begin
            return 32'h0;
        end
        if (len >= LEN_MAX) begin
            return 32'hFFFF_FFFF;
        end
        return 32'hFFFF_FFFF << (LEN_MAX - len);
    endfunction

endpackage

`default_nettype wire

### sv/qtc_ifs.sv
// ----------------------------------------------------------------------------
// qtc channel interfaces
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface qtc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [15:0] ether_type;
    logic [7:0]  tos;
    logic [7:0]  proto;
    logic [15:0] l4_port;
    logic [11:0] vlan_id;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [5:0]  slot;
    logic        entry_valid;
    logic [7:0]  entry_class;
    logic [5:0]  prefix_len;

    modport source (output valid, cmd, ether_type, tos, proto, l4_port, vlan_id,
                    src_addr, dst_addr, slot, entry_valid, entry_class, prefix_len,
                    input ready);
    modport sink (input valid, cmd, ether_type, tos, proto, l4_port, vlan_id,
                  src_addr, dst_addr, slot, entry_valid, entry_class, prefix_len,
                  output ready);
endinterface

interface qtc_out_if;
    logic        valid;
    logic        ready;
    logic        classified;
    logic [2:0]  tclass;
    logic [2:0]  match_source;
    logic [63:0] count_value;

    modport source (output valid, classified, tclass, match_source, count_value,
                    input ready);
    modport sink (input valid, classified, tclass, match_source, count_value,
                  output ready);
endinterface

`default_nettype wire

### sv/qtc_tables.sv
// ----------------------------------------------------------------------------
// qtc lookup tables
// dscp, port, vlan and subnet memories with one write and registered reads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qtc_tables
    import qtc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_tbl_wr i_wr,
    input  wire t_tbl_rd i_rd,
    output t_tbl_q       o_q
);

    logic [7:0]  dscp_mem [DSCP_ENTRIES];
    logic [31:0] port_mem [PORT_ENTRIES];
    logic [19:0] vlan_mem [VLAN_ENTRIES];
    logic [45:0] sub_mem  [SUBNET_ENTRIES];

    // valid bits live in flops so reset clears them at once
    logic [DSCP_ENTRIES-1:0]   r_dscp_vld;
    logic [PORT_ENTRIES-1:0]   r_port_vld;
    logic [VLAN_ENTRIES-1:0]   r_vlan_vld;
    logic [SUBNET_ENTRIES-1:0] r_sub_vld;

    logic [PORT_AW-1:0] port_wa;
    logic [VLAN_AW-1:0] vlan_wa;
    logic [SUB_AW-1:0]  sub_wa;
    t_tbl_q             r_q;

    assign port_wa = PORT_AW'(i_wr.slot);
    assign vlan_wa = VLAN_AW'(i_wr.slot);
    assign sub_wa  = SUB_AW'(i_wr.slot);
    assign o_q     = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dscp_vld <= '0;
            r_port_vld <= '0;
            r_vlan_vld <= '0;
            r_sub_vld  <= '0;
        end else begin
            if (i_wr.we_dscp) begin
                r_dscp_vld[i_wr.slot] <= i_wr.valid;
            end
            if (i_wr.we_port) begin
                r_port_vld[port_wa] <= i_wr.valid;
            end
            if (i_wr.we_vlan) begin
                r_vlan_vld[vlan_wa] <= i_wr.valid;
            end
            if (i_wr.we_sub) begin
                r_sub_vld[sub_wa] <= i_wr.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_dscp) begin
            dscp_mem[i_wr.slot] <= i_wr.cls;
        end
        if (i_wr.we_port) begin
            port_mem[port_wa] <= {i_wr.proto, i_wr.port, i_wr.cls};
        end
        if (i_wr.we_vlan) begin
            vlan_mem[vlan_wa] <= {i_wr.vid, i_wr.cls};
        end
        if (i_wr.we_sub) begin
            sub_mem[sub_wa] <= {i_wr.prefix, i_wr.len, i_wr.cls};
        end
    end

    always_ff @(posedge i_clk) begin
        r_q.dscp_v   <= r_dscp_vld[i_rd.dscp_addr];
        r_q.dscp_cls <= dscp_mem[i_rd.dscp_addr];
        r_q.port_v   <= r_port_vld[i_rd.port_addr];
        {r_q.port_proto, r_q.port_port, r_q.port_cls} <= port_mem[i_rd.port_addr];
        r_q.vlan_v   <= r_vlan_vld[i_rd.vlan_addr];
        {r_q.vlan_vid, r_q.vlan_cls} <= vlan_mem[i_rd.vlan_addr];
        r_q.sub_v    <= r_sub_vld[i_rd.sub_addr];
        {r_q.sub_prefix, r_q.sub_len, r_q.sub_cls} <= sub_mem[i_rd.sub_addr];
    end

endmodule

`default_nettype wire

### sv/qos_traffic_classifier_core.sv
// ----------------------------------------------------------------------------
// qos traffic classifier core
// sequences table lookups, counts per class and answers table commands
// ----------------------------------------------------------------------------
// one item at a time: ready only while the sequencer is idle, entered again as a result issues
// a table write, unknown command or skipped packet goes from accept to S_OUT; a counter read
//   passes S_CRD first; S_OUT holds while the previous result is not yet taken
// classify: a dscp hit goes through S_DSCP, S_CNT, S_INC and S_OUT; a miss sweeps port, vlan,
//   then source and destination subnet tables one entry a cycle, draining each read in turn
// synchronous reset clears all valid bits and counter valid bits
`timescale 1ns / 1ps
`default_nettype none
`include "qos_traffic_classifier_core_macros.svh"

module qos_traffic_classifier_core
    import qtc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    qtc_in_if.sink    i_in,
    qtc_out_if.source o_out,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_idx,
    input  wire logic [7:0] i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DSCP = 4'd1;
    localparam logic [3:0] S_PORT = 4'd2;
    localparam logic [3:0] S_VLAN = 4'd3;
    localparam logic [3:0] S_SRC  = 4'd4;
    localparam logic [3:0] S_DST  = 4'd5;
    localparam logic [3:0] S_CNT  = 4'd6;
    localparam logic [3:0] S_INC  = 4'd7;
    localparam logic [3:0] S_CRD  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]  r_state;
    logic        r_enabled;
    logic [7:0]  r_default;

    logic [7:0]  r_proto;
    logic [15:0] r_port;
    logic [11:0] r_vid;
    logic [31:0] r_src;
    logic [31:0] r_dst;
    logic [5:0]  r_slot;
    logic [7:0]  r_cls;
    logic [2:0]  r_msrc;
    logic [2:0]  r_tc;
    logic        r_hit;
    logic [5:0]  r_best;

    logic [IDX_W-1:0] r_idx;
    logic             r_pend;
    logic             r_qlast;

    logic        r_res_classified;
    logic [2:0]  r_res_tc;
    logic [2:0]  r_res_src;
    logic [63:0] r_res_count;

    logic        r_ovld;
    logic        r_o_classified;
    logic [2:0]  r_o_tc;
    logic [2:0]  r_o_src;
    logic [63:0] r_o_count;

    logic [63:0] cnt_mem [8];
    logic [7:0]  r_cnt_vld;
    logic [63:0] r_cq;
    logic        r_cq_v;
    logic [2:0]  cnt_ra;
    logic        cnt_we;
    logic [63:0] cnt_wd;

    t_tbl_wr tbl_wr;
    t_tbl_rd tbl_rd;
    t_tbl_q  tbl_q;

    logic             in_acc;
    logic             in_valid_ent;
    logic [5:0]       wr_len;
    logic [IDX_W-1:0] sw_depth;
    logic             sw_issue;
    logic             sw_last;
    logic             port_hit;
    logic             vlan_hit;
    logic [31:0]      lpm_addr;
    logic             lpm_match;
    logic             lpm_upd;
    logic [7:0]       fin_cls;

    assign in_acc       = i_in.valid && i_in.ready;
    assign i_in.ready   = (r_state == S_IDLE);
    assign in_valid_ent = i_in.entry_valid;

    assign o_out.valid         = r_ovld;
    assign o_out.classified    = r_o_classified;
    assign o_out.tclass        = r_o_tc;
    assign o_out.match_source  = r_o_src;
    assign o_out.count_value   = r_o_count;

    // table write port straight from the accepted item
    always_comb begin
        wr_len = (i_in.prefix_len > LEN_MAX) ? LEN_MAX : i_in.prefix_len;
        if (!in_valid_ent) begin
            wr_len = 6'd0;
        end
        tbl_wr.we_dscp = in_acc && (i_in.cmd == CMD_WR_DSCP);
        tbl_wr.we_port = in_acc && (i_in.cmd == CMD_WR_PORT)
                         && (32'(i_in.slot) < 32'(PORT_ENTRIES));
        tbl_wr.we_vlan = in_acc && (i_in.cmd == CMD_WR_VLAN)
                         && (32'(i_in.slot) < 32'(VLAN_ENTRIES));
        tbl_wr.we_sub  = in_acc && (i_in.cmd == CMD_WR_SUB)
                         && (32'(i_in.slot) < 32'(SUBNET_ENTRIES));
        tbl_wr.slot    = i_in.slot;
        tbl_wr.valid   = in_valid_ent;
        tbl_wr.cls     = in_valid_ent ? i_in.entry_class : 8'd0;
        tbl_wr.proto   = in_valid_ent ? i_in.proto : 8'd0;
        tbl_wr.port    = in_valid_ent ? i_in.l4_port : 16'd0;
        tbl_wr.vid     = in_valid_ent ? i_in.vlan_id : 12'd0;
        tbl_wr.prefix  = in_valid_ent ? (i_in.src_addr & f_prefix_mask(wr_len)) : 32'd0;
        tbl_wr.len     = wr_len;
    end

    assign tbl_rd.dscp_addr = i_in.tos[7:2];
    assign tbl_rd.port_addr = r_idx[PORT_AW-1:0];
    assign tbl_rd.vlan_addr = r_idx[VLAN_AW-1:0];
    assign tbl_rd.sub_addr  = r_idx[SUB_AW-1:0];

    qtc_tables u_tables (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (tbl_wr),
        .i_rd    (tbl_rd),
        .o_q     (tbl_q)
    );

    // sweep over the table of the current phase
    always_comb begin
        case (r_state)
            S_PORT:  sw_depth = IDX_W'(PORT_ENTRIES);
            S_VLAN:  sw_depth = IDX_W'(VLAN_ENTRIES);
            default: sw_depth = IDX_W'(SUBNET_ENTRIES);
        endcase
        sw_issue  = (r_idx < sw_depth);
        sw_last   = (r_idx == (sw_depth - IDX_W'(1)));
        port_hit  = tbl_q.port_v && (tbl_q.port_proto == r_proto)
                    && (tbl_q.port_port == r_port);
        vlan_hit  = tbl_q.vlan_v && (tbl_q.vlan_vid == r_vid);
        lpm_addr  = (r_state == S_SRC) ? r_src : r_dst;
        lpm_match = tbl_q.sub_v
                    && (((lpm_addr ^ tbl_q.sub_prefix) & f_prefix_mask(tbl_q.sub_len))
                        == 32'd0);
        // subnet reads run during every sweep, only the subnet phases may use them
        lpm_upd   = ((r_state == S_SRC) || (r_state == S_DST))
                    && r_pend && lpm_match && (!r_hit || (tbl_q.sub_len > r_best));
        fin_cls   = (r_cls > CLASS_MAX) ? {5'd0, r_default[2:0]} : r_cls;
    end

    // class counters: read, add one, write back
    assign cnt_ra = (r_state == S_CNT) ? fin_cls[2:0] : i_in.slot[2:0];
    assign cnt_we = (r_state == S_INC);
    assign cnt_wd = (r_cq_v ? r_cq : 64'd0) + 64'd1;

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[r_tc] <= cnt_wd;
        end
        r_cq   <= cnt_mem[cnt_ra];
        r_cq_v <= r_cnt_vld[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
        end else if (cnt_we) begin
            r_cnt_vld[r_tc] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_default <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLED: r_enabled <= i_cfg_data[0];
                CFG_DEFAULT: r_default <= i_cfg_data;
                default:     r_enabled <= r_enabled;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_qlast <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            if (r_ovld && o_out.ready && (r_state != S_OUT)) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_proto          <= i_in.proto;
                        r_port           <= i_in.l4_port;
                        r_vid            <= i_in.vlan_id;
                        r_src            <= i_in.src_addr;
                        r_dst            <= i_in.dst_addr;
                        r_slot           <= i_in.slot;
                        r_cls            <= r_default;
                        r_msrc           <= SRC_DEFAULT;
                        r_res_classified <= 1'b0;
                        r_res_tc         <= 3'd0;
                        r_res_src        <= SRC_DEFAULT;
                        r_res_count      <= 64'd0;
                        case (i_in.cmd)
                            CMD_CLASSIFY: begin
                                if (r_enabled && (i_in.ether_type == ETH_IPV4)) begin
                                    r_state <= S_DSCP;
                                end else begin
                                    r_state <= S_OUT;
                                end
                            end
                            CMD_READ: r_state <= S_CRD;
                            default:  r_state <= S_OUT;
                        endcase
                    end
                end
                S_DSCP: begin
                    r_idx   <= '0;
                    r_pend  <= 1'b0;
                    r_qlast <= 1'b0;
                    r_hit   <= 1'b0;
                    if (tbl_q.dscp_v) begin
                        r_cls   <= tbl_q.dscp_cls;
                        r_msrc  <= SRC_DSCP;
                        r_state <= S_CNT;
                    end else begin
                        r_state <= S_PORT;
                    end
                end
                S_PORT, S_VLAN, S_SRC, S_DST: begin
                    if (sw_issue) begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_pend  <= 1'b1;
                        r_qlast <= sw_last;
                    end
                    if (lpm_upd) begin
                        r_best <= tbl_q.sub_len;
                        r_cls  <= tbl_q.sub_cls;
                    end
                    if (lpm_upd && !r_qlast) begin
                        r_hit <= 1'b1;
                    end
                    if ((r_state == S_PORT) && r_pend && port_hit) begin
                        r_cls   <= tbl_q.port_cls;
                        r_msrc  <= SRC_PORT;
                        r_state <= S_CNT;
                    end else if ((r_state == S_VLAN) && r_pend && vlan_hit) begin
                        r_cls   <= tbl_q.vlan_cls;
                        r_msrc  <= SRC_VLAN;
                        r_state <= S_CNT;
                    end else if (r_pend && r_qlast) begin
                        // end of this table: move to the next phase
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_qlast <= 1'b0;
                        r_hit   <= 1'b0;
                        case (r_state)
                            S_PORT: r_state <= S_VLAN;
                            S_VLAN: r_state <= S_SRC;
                            S_SRC: begin
                                if (r_hit || lpm_upd) begin
                                    r_msrc  <= SRC_SUBSRC;
                                    r_state <= S_CNT;
                                end else begin
                                    r_state <= S_DST;
                                end
                            end
                            default: begin
                                if (r_hit || lpm_upd) begin
                                    r_msrc <= SRC_SUBDST;
                                end
                                r_state <= S_CNT;
                            end
                        endcase
                    end
                end
                S_CNT: begin
                    r_tc    <= fin_cls[2:0];
                    r_state <= S_INC;
                end
                S_INC: begin
                    r_res_classified <= 1'b1;
                    r_res_tc         <= r_tc;
                    r_res_src        <= r_msrc;
                    r_state          <= S_OUT;
                end
                S_CRD: begin
                    r_res_count <= ((r_slot < 6'd8) && r_cq_v) ? r_cq : 64'd0;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovld || o_out.ready) begin
                        r_ovld         <= 1'b1;
                        r_o_classified <= r_res_classified;
                        r_o_tc         <= r_res_tc;
                        r_o_src        <= r_res_src;
                        r_o_count      <= r_res_count;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `QTC_ASSERT_IMP(a_src_range, i_clk, i_rst_n, r_ovld && r_o_classified, r_o_src <= SRC_SUBDST, "match source out of range")
    `QTC_ASSERT_IMP(a_unclass_zero, i_clk, i_rst_n, r_ovld && !r_o_classified, (r_o_tc == 3'd0) && (r_o_src == SRC_DEFAULT), "unclassified item carries a class")
    `QTC_ASSERT_IMP(a_count_on_read, i_clk, i_rst_n, r_ovld && (r_o_count != 64'd0), !r_o_classified, "count value on a classified item")
    `QTC_ASSERT_NXT(a_write_done, i_clk, i_rst_n, in_acc && (i_in.cmd != CMD_CLASSIFY) && (i_in.cmd != CMD_READ), r_state == S_OUT, "table write did not finish at once")

endmodule

`default_nettype wire

### dv/tb_qos_traffic_classifier_core.sv
// ----------------------------------------------------------------------------
// qos traffic classifier testbench
// drives table writes, counter reads and classify items with random idling
// on both channels and checks every result against a behavioural predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class qtc_scoreboard;
    typedef struct packed {
        logic        classified;
        logic [2:0]  tclass;
        logic [2:0]  match_source;
        logic [63:0] count_value;
    } t_res;

    // predictor state
    bit          enabled;
    bit [7:0]    dflt_class;
    bit          dscp_v[64];
    bit [7:0]    dscp_c[64];
    bit          port_v[64];
    bit [7:0]    port_pr[64];
    bit [15:0]   port_pt[64];
    bit [7:0]    port_c[64];
    bit          vlan_v[64];
    bit [11:0]   vlan_id[64];
    bit [7:0]    vlan_c[64];
    bit          sub_v[32];
    bit [31:0]   sub_pfx[32];
    bit [5:0]    sub_len[32];
    bit [7:0]    sub_c[32];
    bit [63:0]   class_count[8];
    t_res        pending[$];
    int          errors;

    function new();
        errors = 0;
        enabled = 0;
        dflt_class = 0;
        foreach (dscp_v[i]) begin
            dscp_v[i] = 0; dscp_c[i] = 0;
            port_v[i] = 0; port_pr[i] = 0; port_pt[i] = 0; port_c[i] = 0;
            vlan_v[i] = 0; vlan_id[i] = 0; vlan_c[i] = 0;
        end
        foreach (sub_v[i]) begin
            sub_v[i] = 0; sub_pfx[i] = 0; sub_len[i] = 0; sub_c[i] = 0;
        end
        foreach (class_count[i]) class_count[i] = 0;
    endfunction

    function void note_cfg(bit idx, bit [7:0] data);
        if (idx == qtc_pkg::CFG_ENABLED) enabled = data[0];
        else dflt_class = data;
    endfunction

    function bit [31:0] mask_of(bit [5:0] len);
        if (len == 0) return 32'h0;
        if (len >= 32) return 32'hFFFF_FFFF;
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function bit subnet_hit(bit [31:0] addr, output bit [7:0] cls);
        bit hit;
        bit [5:0] best;
        hit = 0;
        best = 0;
        cls = 0;
        for (int i = 0; i < 32; i++) begin
            if (sub_v[i] && (((addr ^ sub_pfx[i]) & mask_of(sub_len[i])) == 0)
                && (!hit || sub_len[i] > best)) begin
                hit = 1;
                best = sub_len[i];
                cls = sub_c[i];
            end
        end
        return hit;
    endfunction

    function void note_item(bit [2:0] cmd, bit [15:0] et, bit [7:0] tos, bit [7:0] pr,
                            bit [15:0] pt, bit [11:0] vid, bit [31:0] sa, bit [31:0] da,
                            bit [5:0] slot, bit ev, bit [7:0] ec, bit [5:0] pl);
        t_res r;
        bit [7:0] cls, c;
        bit [2:0] src;
        bit [5:0] len;
        r = '0;
        if (!ev) ec = 0;
        case (cmd)
            qtc_pkg::CMD_CLASSIFY: begin
                if (enabled && et == qtc_pkg::ETH_IPV4) begin
                    cls = dflt_class;
                    src = qtc_pkg::SRC_DEFAULT;
                    if (dscp_v[tos[7:2]]) begin
                        cls = dscp_c[tos[7:2]];
                        src = qtc_pkg::SRC_DSCP;
                    end
                    for (int i = 0; src == qtc_pkg::SRC_DEFAULT && i < 64; i++)
                        if (port_v[i] && port_pr[i] == pr && port_pt[i] == pt) begin
                            cls = port_c[i];
                            src = qtc_pkg::SRC_PORT;
                        end
                    for (int i = 0; src == qtc_pkg::SRC_DEFAULT && i < 64; i++)
                        if (vlan_v[i] && vlan_id[i] == vid) begin
                            cls = vlan_c[i];
                            src = qtc_pkg::SRC_VLAN;
                        end
                    if (src == qtc_pkg::SRC_DEFAULT && subnet_hit(sa, c)) begin
                        cls = c;
                        src = qtc_pkg::SRC_SUBSRC;
                    end
                    if (src == qtc_pkg::SRC_DEFAULT && subnet_hit(da, c)) begin
                        cls = c;
                        src = qtc_pkg::SRC_SUBDST;
                    end
                    if (cls > 7) cls = dflt_class & 8'h7;
                    class_count[cls[2:0]] += 1;
                    r.classified = 1;
                    r.tclass = cls[2:0];
                    r.match_source = src;
                end
            end
            qtc_pkg::CMD_WR_DSCP: begin
                dscp_v[slot] = ev;
                dscp_c[slot] = ec;
            end
            qtc_pkg::CMD_WR_PORT: begin
                port_v[slot] = ev;
                port_pr[slot] = ev ? pr : 8'h0;
                port_pt[slot] = ev ? pt : 16'h0;
                port_c[slot] = ec;
            end
            qtc_pkg::CMD_WR_VLAN: begin
                vlan_v[slot] = ev;
                vlan_id[slot] = ev ? vid : 12'h0;
                vlan_c[slot] = ec;
            end
            qtc_pkg::CMD_WR_SUB: begin
                if (slot < 32) begin
                    len = (pl > 32) ? 6'd32 : pl;
                    if (!ev) len = 0;
                    sub_v[slot] = ev;
                    sub_len[slot] = len;
                    sub_pfx[slot] = ev ? (sa & mask_of(len)) : 32'h0;
                    sub_c[slot] = ec;
                end
            end
            qtc_pkg::CMD_READ: begin
                if (slot < 8) r.count_value = class_count[slot[2:0]];
            end
            default: ;
        endcase
        pending.push_back(r);
    endfunction

    function void check_result(bit cl, bit [2:0] tc, bit [2:0] ms, bit [63:0] cv);
        t_res e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result cl=%0d tc=%0d ms=%0d cv=%0h",
                     $time, cl, tc, ms, cv);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (cl !== e.classified) begin
            $display("%0t: classified exp %0d got %0d", $time, e.classified, cl);
            errors++;
        end
        if (tc !== e.tclass) begin
            $display("%0t: tclass exp %0d got %0d", $time, e.tclass, tc);
            errors++;
        end
        if (ms !== e.match_source) begin
            $display("%0t: match_source exp %0d got %0d", $time, e.match_source, ms);
            errors++;
        end
        if (cv !== e.count_value) begin
            $display("%0t: count_value exp %0h got %0h", $time, e.count_value, cv);
            errors++;
        end
    endfunction
endclass

module tb_qos_traffic_classifier_core;
    import qtc_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    qtc_in_if  in_ch();
    qtc_out_if out_ch();

    qos_traffic_classifier_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    qtc_scoreboard sb;
    int  cycle_count;
    bit  calm;       // no idling in the last part
    bit  hold_long;  // receiver long stall request
    localparam int CYCLE_LIMIT = 3_000_000;

    // classifier state for directed keys
    logic [2:0]  c_cmd;
    logic [15:0] c_et, c_pt;
    logic [7:0]  c_tos, c_pr, c_ec;
    logic [11:0] c_vid;
    logic [31:0] c_sa, c_da;
    logic [5:0]  c_slot, c_pl;
    logic        c_ev;

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // result side: check accepted items, random stalls
    initial begin
        int gap;
        out_ch.ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.classified, out_ch.tclass,
                                out_ch.match_source, out_ch.count_value);
            if (hold_long) begin
                out_ch.ready <= 0;
                repeat (400) @(posedge i_clk);
                hold_long = 0;
                out_ch.ready <= 1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 10);
                out_ch.ready <= 0;
                repeat (gap) begin
                    @(posedge i_clk);
                end
                out_ch.ready <= 1;
            end else begin
                out_ch.ready <= 1;
            end
        end
    end

    task automatic send_item();
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            in_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1;
        in_ch.cmd         <= c_cmd;
        in_ch.ether_type  <= c_et;
        in_ch.tos         <= c_tos;
        in_ch.proto       <= c_pr;
        in_ch.l4_port     <= c_pt;
        in_ch.vlan_id     <= c_vid;
        in_ch.src_addr    <= c_sa;
        in_ch.dst_addr    <= c_da;
        in_ch.slot        <= c_slot;
        in_ch.entry_valid <= c_ev;
        in_ch.entry_class <= c_ec;
        in_ch.prefix_len  <= c_pl;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(c_cmd, c_et, c_tos, c_pr, c_pt, c_vid, c_sa, c_da,
                     c_slot, c_ev, c_ec, c_pl);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [7:0] data);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.note_cfg(idx, data);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // small key pools so random classify items hit table entries
    logic [7:0]  pool_pr[4];
    logic [15:0] pool_pt[4];
    logic [11:0] pool_vid[4];
    logic [31:0] pool_net[4];

    task automatic random_fields();
        c_cmd  = 3'($urandom_range(0, 7));
        c_et   = ($urandom_range(0, 7) != 0) ? ETH_IPV4 : 16'($urandom);
        c_tos  = 8'($urandom);
        c_pr   = ($urandom_range(0, 1)) ? pool_pr[$urandom_range(0, 3)] : 8'($urandom);
        c_pt   = ($urandom_range(0, 1)) ? pool_pt[$urandom_range(0, 3)] : 16'($urandom);
        c_vid  = ($urandom_range(0, 1)) ? pool_vid[$urandom_range(0, 3)] : 12'($urandom);
        c_sa   = ($urandom_range(0, 1)) ? (pool_net[$urandom_range(0, 3)] ^ 32'($urandom_range(0, 255)))
                                        : $urandom;
        c_da   = ($urandom_range(0, 1)) ? (pool_net[$urandom_range(0, 3)] ^ 32'($urandom_range(0, 65535)))
                                        : $urandom;
        c_slot = 6'($urandom);
        c_ev   = ($urandom_range(0, 3) != 0);
        c_ec   = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        c_pl   = 6'($urandom);
    endtask

    task automatic random_phase(int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            random_fields();
            pick = $urandom_range(0, 99);
            // mostly classify, some table updates and reads
            if (pick < 55) c_cmd = CMD_CLASSIFY;
            else if (pick < 62) c_cmd = CMD_WR_DSCP;
            else if (pick < 70) c_cmd = CMD_WR_PORT;
            else if (pick < 78) c_cmd = CMD_WR_VLAN;
            else if (pick < 88) c_cmd = CMD_WR_SUB;
            else if (pick < 96) c_cmd = CMD_READ;
            if (c_cmd == CMD_READ && $urandom_range(0, 3) != 0)
                c_slot = 6'($urandom_range(0, 7));
            if (c_cmd == CMD_WR_SUB && $urandom_range(0, 3) != 0)
                c_slot = 6'($urandom_range(0, 31));
            send_item();
        end
    endtask

    initial begin
        sb = new();
        calm = 0;
        hold_long = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = 0;
        i_cfg_data = 0;
        in_ch.valid = 0;
        in_ch.cmd = 0; in_ch.ether_type = 0; in_ch.tos = 0; in_ch.proto = 0;
        in_ch.l4_port = 0; in_ch.vlan_id = 0; in_ch.src_addr = 0; in_ch.dst_addr = 0;
        in_ch.slot = 0; in_ch.entry_valid = 0; in_ch.entry_class = 0; in_ch.prefix_len = 0;
        foreach (pool_pr[i]) begin
            pool_pr[i] = 8'($urandom); pool_pt[i] = 16'($urandom);
            pool_vid[i] = 12'($urandom); pool_net[i] = $urandom;
        end
        pool_pr[0] = 8'hFF; pool_pt[0] = 16'hFFFF; pool_vid[0] = 12'hFFF;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // disabled: packet passes unclassified
        c_cmd = CMD_CLASSIFY; c_et = ETH_IPV4; c_tos = 8'hFF; c_pr = 0; c_pt = 0;
        c_vid = 0; c_sa = 0; c_da = 0; c_slot = 0; c_ev = 0; c_ec = 0; c_pl = 0;
        send_item();
        drain();
        write_cfg(CFG_ENABLED, 8'h1);
        write_cfg(CFG_DEFAULT, 8'hFF);

        // default path with class above 7, then non-ipv4 and unknown commands
        send_item();
        c_et = 16'hFFFF; send_item();
        c_et = ETH_IPV4; c_cmd = 3'd6; send_item();
        c_cmd = 3'd7; c_slot = 6'h3F; c_ev = 1; c_ec = 8'hFF; send_item();
        // dscp entry with class above 7, dscp 63
        c_cmd = CMD_WR_DSCP; c_slot = 6'h3F; c_ev = 1; c_ec = 8'h0A; send_item();
        c_cmd = CMD_CLASSIFY; send_item();
        // duplicate port keys, the lower slot wins
        c_cmd = CMD_WR_PORT; c_pr = 8'hFF; c_pt = 16'hFFFF; c_slot = 6'd5; c_ec = 8'd3;
        send_item();
        c_slot = 6'd2; c_ec = 8'd6; send_item();
        c_cmd = CMD_CLASSIFY; c_tos = 0; send_item();
        // remove port entries, vlan hit
        c_cmd = CMD_WR_PORT; c_ev = 0; c_slot = 6'd2; send_item();
        c_slot = 6'd5; send_item();
        c_cmd = CMD_WR_VLAN; c_ev = 1; c_vid = 12'hFFF; c_slot = 6'd63; c_ec = 8'd1;
        send_item();
        c_cmd = CMD_CLASSIFY; send_item();
        // subnet: saturated length, longest prefix, slot beyond table ignored
        c_vid = 0;
        c_cmd = CMD_WR_SUB; c_sa = 32'hFFFF_FFFF; c_pl = 6'h3F; c_slot = 6'd31; c_ec = 8'd4;
        send_item();
        c_pl = 6'd8; c_slot = 6'd0; c_ec = 8'd2; send_item();
        c_slot = 6'd40; c_ec = 8'd7; send_item();
        c_cmd = CMD_CLASSIFY; c_sa = 32'hFF00_0001; send_item();
        c_sa = 32'hFFFF_FFFF; send_item();
        c_sa = 0; c_da = 32'hFF12_3456; send_item();
        // prefix length zero matches everything
        c_cmd = CMD_WR_SUB; c_pl = 0; c_slot = 6'd1; c_ec = 8'd5; send_item();
        c_cmd = CMD_CLASSIFY; c_da = 0; send_item();
        // counter reads, including class above 7
        c_cmd = CMD_READ;
        for (int s = 0; s < 8; s++) begin c_slot = 6'(s); send_item(); end
        c_slot = 6'h3F; send_item();
        drain();

        // clear the catch-all and start random work
        c_cmd = CMD_WR_SUB; c_ev = 0; c_slot = 6'd1; send_item();
        random_phase(400);
        drain();
        write_cfg(CFG_DEFAULT, 8'd0);
        random_phase(300);
        // long receiver stall while items keep coming
        hold_long = 1;
        random_phase(200);
        drain();
        write_cfg(CFG_ENABLED, 8'h0);
        random_phase(150);
        drain();
        write_cfg(CFG_ENABLED, 8'h1);
        write_cfg(CFG_DEFAULT, 8'($urandom_range(0, 255)));
        random_phase(400);
        drain();
        write_cfg(CFG_DEFAULT, 8'd7);
        calm = 1;
        random_phase(350);
        drain();
        repeat (50) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
